// ===== rtl/core/srp_pkg.sv =====
// shared types and constants of the skyline rectangle packer
package srp_pkg;

   // bin geometry
   localparam int MAX_COLUMNS = 256;
   localparam int MAX_HEIGHT  = 4095;
   localparam int COL_W       = $clog2(MAX_COLUMNS);
   localparam int CNT_W       = $clog2(MAX_COLUMNS + 1);
   localparam int HGT_W       = 12;
   localparam int WID_W       = 9;
   localparam int CSR_W       = 12;
   localparam int CSR_IDX_W   = 1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BIN_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BIN_HEIGHT = 1'b1;

   // operation codes
   localparam logic OP_PLACE = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   typedef struct packed {
      logic             operation;
      logic [WID_W-1:0] rect_width;
      logic [HGT_W-1:0] rect_height;
   } req_type;

   typedef struct packed {
      logic             placed;
      logic [7:0]       pos_x;
      logic [HGT_W-1:0] pos_y;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WRITE
   } state_type;

endpackage

// ===== rtl/core/skyline_rect_packer.sv =====
// skyline rectangle packer: first-fit scan and skyline update
// a clear or rejected request is answered straight from idle; a scan that finds no fitting
//   position ends after the last column; a placement goes on to raise its columns in ST_WRITE
// throughput: one item at a time, the next item is taken at the edge that takes the result
// the scan reads one column a cycle from the skyline memory port; the receiver cannot stall
// reset (synchronous): skyline reads as zero, bin_width 256, bin_height 4095, idle
module skyline_rect_packer (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  srp_pkg::req_type                   req_data,
   output logic                               rsp_strobe,
   output srp_pkg::rsp_type                   rsp_data,
   input  logic                               csr_we,
   input  logic [srp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [srp_pkg::CSR_W-1:0]          csr_wdata
);

   // configuration registers
   logic [srp_pkg::WID_W-1:0] bin_width_ff;
   logic [srp_pkg::HGT_W-1:0] bin_height_ff;

   // sequencer state
   srp_pkg::state_type        state_ff, state_in;
   srp_pkg::req_type          req_ff, req_in;
   logic [srp_pkg::CNT_W-1:0] rd_ff, rd_in;
   logic                      pend_ff, pend_in;
   logic [srp_pkg::CNT_W-1:0] idx_ff, idx_in;
   logic [srp_pkg::CNT_W-1:0] x_ff, x_in;
   logic [srp_pkg::HGT_W-1:0] top_ff, top_in;
   logic [srp_pkg::CNT_W-1:0] wa_ff, wa_in;
   logic [srp_pkg::CNT_W-1:0] wleft_ff, wleft_in;
   logic                      rsp_strobe_ff, rsp_strobe_in;
   srp_pkg::rsp_type          rsp_ff, rsp_in;

   // skyline memory with per-column valid bits
   logic [srp_pkg::HGT_W-1:0]       mem [srp_pkg::MAX_COLUMNS];
   logic [srp_pkg::MAX_COLUMNS-1:0] vld_ff;
   logic [srp_pkg::HGT_W-1:0]       mem_q_ff;
   logic                            vld_q_ff;

   logic                      rd_en;
   logic                      mem_we;
   logic                      vld_clear;
   logic [srp_pkg::COL_W-1:0] rd_addr;
   logic [srp_pkg::COL_W-1:0] wr_addr;
   logic [srp_pkg::HGT_W-1:0] wr_data;

   // datapath helpers
   logic [srp_pkg::CNT_W-1:0] eff_bw;
   logic [srp_pkg::CNT_W-1:0] rw_ext;
   logic [srp_pkg::HGT_W-1:0] col;
   logic                      fits;
   logic [srp_pkg::HGT_W-1:0] new_top;
   logic [srp_pkg::CNT_W-1:0] win_len;

   assign busy       = (state_ff != srp_pkg::ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // columns beyond the memory are not used
   assign eff_bw = (bin_width_ff > srp_pkg::WID_W'(srp_pkg::MAX_COLUMNS)) ?
                   srp_pkg::CNT_W'(srp_pkg::MAX_COLUMNS) : srp_pkg::CNT_W'(bin_width_ff);

   // shared compare unit on the column coming out of the memory
   assign rw_ext  = srp_pkg::CNT_W'(req_ff.rect_width);
   assign col     = vld_q_ff ? mem_q_ff : '0;
   assign fits    = ({1'b0, col} + {1'b0, req_ff.rect_height}) <= {1'b0, bin_height_ff};
   assign new_top = (col > top_ff) ? col : top_ff;
   assign win_len = idx_ff - x_ff + srp_pkg::CNT_W'(1);
   assign rd_addr = rd_ff[srp_pkg::COL_W-1:0];
   assign wr_addr = wa_ff[srp_pkg::COL_W-1:0];
   assign wr_data = top_ff + req_ff.rect_height;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         bin_width_ff  <= srp_pkg::WID_W'(256);
         bin_height_ff <= srp_pkg::HGT_W'(srp_pkg::MAX_HEIGHT);
      end else if (csr_we) begin
         case (csr_index)
            srp_pkg::CSR_BIN_WIDTH:  bin_width_ff  <= csr_wdata[srp_pkg::WID_W-1:0];
            srp_pkg::CSR_BIN_HEIGHT: bin_height_ff <= csr_wdata[srp_pkg::HGT_W-1:0];
            default: ;
         endcase
      end
   end

   // skyline memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         mem_q_ff <= mem[rd_addr];
         vld_q_ff <= vld_ff[rd_addr];
      end
   end

   // valid bits, cleared by reset and by the clear operation
   always_ff @(posedge clock) begin
      if (reset || vld_clear) begin
         vld_ff <= '0;
      end else if (mem_we) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   // sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= srp_pkg::ST_IDLE;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      rd_ff    <= rd_in;
      idx_ff   <= idx_in;
      x_ff     <= x_in;
      top_ff   <= top_in;
      wa_ff    <= wa_in;
      wleft_ff <= wleft_in;
      rsp_ff   <= rsp_in;
   end

   // next state and controls
   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      rd_in         = rd_ff;
      pend_in       = 1'b0;
      idx_in        = idx_ff;
      x_in          = x_ff;
      top_in        = top_ff;
      wa_in         = wa_ff;
      wleft_in      = wleft_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      rd_en         = 1'b0;
      mem_we        = 1'b0;
      vld_clear     = 1'b0;

      case (state_ff)
         srp_pkg::ST_IDLE: begin
            if (start) begin
               req_in = req_data;
               rsp_in = '0;
               if (req_data.operation == srp_pkg::OP_CLEAR) begin
                  vld_clear     = 1'b1;
                  rsp_strobe_in = 1'b1;
               end else if (req_data.rect_width == '0 ||
                            srp_pkg::CNT_W'(req_data.rect_width) > eff_bw) begin
                  // zero width or wider than the bin
                  rsp_strobe_in = 1'b1;
               end else begin
                  rd_in    = '0;
                  x_in     = '0;
                  top_in   = '0;
                  state_in = srp_pkg::ST_SCAN;
               end
            end
         end

         srp_pkg::ST_SCAN: begin
            // issue the next column read
            if (rd_ff < eff_bw) begin
               rd_en   = 1'b1;
               pend_in = 1'b1;
               idx_in  = rd_ff;
               rd_in   = rd_ff + srp_pkg::CNT_W'(1);
            end
            // evaluate the column read last cycle
            if (pend_ff) begin
               if (!fits) begin
                  // window restarts past a column that is too tall
                  x_in   = idx_ff + srp_pkg::CNT_W'(1);
                  top_in = '0;
               end else if (win_len == rw_ext) begin
                  top_in   = new_top;
                  wa_in    = x_ff;
                  wleft_in = rw_ext;
                  pend_in  = 1'b0;
                  state_in = srp_pkg::ST_WRITE;
               end else begin
                  top_in = new_top;
               end
               if (idx_ff == eff_bw - srp_pkg::CNT_W'(1) &&
                   !(fits && win_len == rw_ext)) begin
                  // no fitting position
                  pend_in       = 1'b0;
                  rsp_strobe_in = 1'b1;
                  rsp_in        = '0;
                  state_in      = srp_pkg::ST_IDLE;
               end
            end
         end

         srp_pkg::ST_WRITE: begin
            // raise the covered columns one per cycle
            mem_we   = 1'b1;
            wa_in    = wa_ff + srp_pkg::CNT_W'(1);
            wleft_in = wleft_ff - srp_pkg::CNT_W'(1);
            if (wleft_ff == srp_pkg::CNT_W'(1)) begin
               rsp_strobe_in = 1'b1;
               rsp_in.placed = 1'b1;
               rsp_in.pos_x  = x_ff[7:0];
               rsp_in.pos_y  = top_ff;
               state_in      = srp_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = srp_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== tb/skyline_rect_packer_test.sv =====
// self-checking testbench for the skyline rectangle packer
`timescale 1ns / 100ps

module skyline_rect_packer_test;
   import srp_pkg::*;

   localparam int STALL_LIMIT = 4000;
   localparam int PHASE_ITEMS = 180;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_data = '0;
   logic rsp_strobe;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0] csr_wdata = '0;

   // predictor state: skyline and register copies
   logic [HGT_W-1:0] skyline [MAX_COLUMNS];
   logic [WID_W-1:0] cfg_bin_width = 9'd256;
   logic [HGT_W-1:0] cfg_bin_height = 12'd4095;

   req_type queued_requests[$];
   rsp_type expected_placements[$];

   int requests_issued = 0;
   int results_seen = 0;
   int mismatch_count = 0;
   int placed_total = 0;
   int rejected_total = 0;
   int clear_total = 0;
   int csr_writes = 0;
   int stall_cycles = 0;
   int gap_left = 0;
   bit sender_pauses = 1'b0;

   skyline_rect_packer i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // first-fit placement on the local skyline copy
   function automatic rsp_type predict_placement(req_type r);
      rsp_type res;
      int eff_w, bh, rw, rh, x, i, y, col, blocked;
      res = '0;
      eff_w = (cfg_bin_width > MAX_COLUMNS) ? MAX_COLUMNS : int'(cfg_bin_width);
      bh = int'(cfg_bin_height);
      rw = int'(r.rect_width);
      rh = int'(r.rect_height);
      if (r.operation == OP_CLEAR) begin
         for (i = 0; i < MAX_COLUMNS; i++) skyline[i] = '0;
         clear_total++;
         return res;
      end
      if (rw == 0 || rw > eff_w) begin
         rejected_total++;
         return res;
      end
      x = 0;
      while (!res.placed && x + rw <= eff_w) begin
         blocked = -1;
         y = 0;
         for (i = x; i < x + rw; i++) begin
            col = int'(skyline[i]);
            if (col + rh > bh) blocked = i;
            if (col > y) y = col;
         end
         // skip past the rightmost column that cannot take the rectangle
         if (blocked >= 0) begin
            x = blocked + 1;
         end else begin
            for (i = x; i < x + rw; i++) skyline[i] = 12'(y + rh);
            res.placed = 1'b1;
            res.pos_x = 8'(x);
            res.pos_y = 12'(y);
         end
      end
      if (res.placed) placed_total++;
      else rejected_total++;
      return res;
   endfunction

   // item driver with random pause bursts
   always @(posedge clock) begin : driver
      if (start && !busy) expected_placements.push_back(predict_placement(req_data));
      if (!start || !busy) begin
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (queued_requests.size() != 0 && sender_pauses &&
                      $urandom_range(0, 3) == 0) begin
            gap_left = $urandom_range(0, 15);
            start <= 1'b0;
         end else if (queued_requests.size() != 0) begin
            start <= 1'b1;
            req_data <= queued_requests.pop_front();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // result checker and stall watchdog
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (!reset && rsp_strobe) begin
         results_seen++;
         if (expected_placements.size() == 0) begin
            $error("unexpected result: placed %0d pos_x %0d pos_y %0d",
                   rsp_data.placed, rsp_data.pos_x, rsp_data.pos_y);
            mismatch_count++;
         end else begin
            want = expected_placements.pop_front();
            if (rsp_data.placed !== want.placed) begin
               $error("placed: expected %0d, actual %0d", want.placed, rsp_data.placed);
               mismatch_count++;
            end
            if (rsp_data.pos_x !== want.pos_x) begin
               $error("pos_x: expected %0d, actual %0d", want.pos_x, rsp_data.pos_x);
               mismatch_count++;
            end
            if (rsp_data.pos_y !== want.pos_y) begin
               $error("pos_y: expected %0d, actual %0d", want.pos_y, rsp_data.pos_y);
               mismatch_count++;
            end
         end
      end
      if ((start && !busy) || rsp_strobe) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic push_request(logic op, logic [WID_W-1:0] w, logic [HGT_W-1:0] h);
      req_type item;
      item.operation = op;
      item.rect_width = w;
      item.rect_height = h;
      queued_requests.push_back(item);
      requests_issued++;
   endtask

   // wait until every item has returned its result
   task automatic drain();
      while (results_seen != requests_issued) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_BIN_WIDTH) cfg_bin_width = value[WID_W-1:0];
      else cfg_bin_height = value[HGT_W-1:0];
      csr_writes++;
   endtask

   initial begin : stimulus
      int phase, n, eff_w, sel, hsel, w_val, h_val;
      req_type item;
      for (int i = 0; i < MAX_COLUMNS; i++) skyline[i] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      sender_pauses = 1'b1;

      // full bin, exact fits, zero and oversized widths, clear
      push_request(OP_PLACE, 9'd256, 12'd4095);
      push_request(OP_PLACE, 9'd1, 12'd0);
      push_request(OP_PLACE, 9'd1, 12'd1);
      push_request(OP_CLEAR, 9'd511, 12'd4095);
      push_request(OP_PLACE, 9'd0, 12'd5);
      push_request(OP_PLACE, 9'd257, 12'd1);
      push_request(OP_PLACE, 9'd511, 12'd4095);
      push_request(OP_PLACE, 9'd1, 12'd4095);
      push_request(OP_PLACE, 9'd2, 12'd10);
      push_request(OP_PLACE, 9'd256, 12'd1);
      push_request(OP_PLACE, 9'd255, 12'd100);
      push_request(OP_PLACE, 9'd128, 12'd0);
      drain();

      // zero bin width rejects everything
      write_csr(CSR_BIN_WIDTH, 12'hE00);
      push_request(OP_PLACE, 9'd1, 12'd1);
      push_request(OP_PLACE, 9'd0, 12'd0);
      drain();

      // bin width beyond the column count saturates
      write_csr(CSR_BIN_WIDTH, 12'h1FF);
      push_request(OP_PLACE, 9'd256, 12'd2);
      push_request(OP_PLACE, 9'd256, 12'd3);
      drain();

      // single column with zero height limit
      write_csr(CSR_BIN_WIDTH, 12'd1);
      write_csr(CSR_BIN_HEIGHT, 12'd0);
      push_request(OP_PLACE, 9'd1, 12'd0);
      push_request(OP_PLACE, 9'd1, 12'd1);
      push_request(OP_PLACE, 9'd2, 12'd0);
      drain();

      write_csr(CSR_BIN_HEIGHT, 12'hFFF);
      write_csr(CSR_BIN_WIDTH, 12'd256);
      push_request(OP_CLEAR, 9'd0, 12'd0);
      push_request(OP_PLACE, 9'd256, 12'd0);
      drain();

      // random phases, each with its own bin geometry
      for (phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin w_val = 256; h_val = 4095; end
            1: begin w_val = $urandom_range(2, 16); h_val = $urandom_range(16, 255); end
            2: begin w_val = 1; h_val = $urandom_range(1, 4095); end
            3: begin w_val = $urandom_range(257, 511); h_val = 4095; end
            4: begin w_val = $urandom_range(1, 256); h_val = $urandom_range(1, 4095); end
            5: begin w_val = $urandom_range(100, 256); h_val = 1; end
            6: begin w_val = $urandom_range(17, 64); h_val = $urandom_range(256, 1023); end
            default: begin w_val = 256; h_val = 4095; end
         endcase
         sender_pauses = (phase != 3 && phase != 7);
         write_csr(CSR_BIN_WIDTH, {3'($urandom), 9'(w_val)});
         write_csr(CSR_BIN_HEIGHT, 12'(h_val));
         eff_w = (cfg_bin_width > MAX_COLUMNS) ? MAX_COLUMNS : int'(cfg_bin_width);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            sel = $urandom_range(0, 31);
            hsel = $urandom_range(0, 15);
            item = '0;
            if (sel == 0) begin
               item.operation = OP_CLEAR;
               item.rect_width = 9'($urandom);
               item.rect_height = 12'($urandom);
            end else begin
               item.operation = OP_PLACE;
               // mostly fitting widths, some noise over the whole field
               if (sel == 1) item.rect_width = 9'($urandom_range(0, 511));
               else if (sel <= 16) item.rect_width = 9'($urandom_range(1, (eff_w + 3) / 4));
               else item.rect_width = 9'($urandom_range(1, eff_w));
               if (hsel == 0) item.rect_height = '0;
               else if (hsel == 1) item.rect_height = 12'($urandom_range(0, 4095));
               else item.rect_height = 12'($urandom_range(1, cfg_bin_height / 4 + 1));
            end
            push_request(item.operation, item.rect_width, item.rect_height);
         end
         drain();
      end

      repeat (16) @(posedge clock);
      $display("covered %0d items over %0d register writes", requests_issued, csr_writes);
      $display("%0d placed, %0d rejected, %0d clears", placed_total, rejected_total,
               clear_total);
      if (mismatch_count == 0 && expected_placements.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
